>>> rtl/core/brlm_pkg.sv
// Shared types and constants for the block RMS level meter.
`timescale 1ns / 1ps

package brlm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int SUM_BITS    = 43;
   localparam int LIMIT_BITS  = 16;
   localparam int RAD_BITS    = 32;
   localparam int ROOT_BITS   = 16;
   localparam int STEP_BITS   = 6;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd22938;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_SETTLE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic emit;
   } cmd_type;

endpackage

>>> rtl/core/block_rms_level_meter_core.sv
// Top level of the block RMS level meter.
`timescale 1ns / 1ps

// Samples are taken one per clock while busy is low. A request with
// req_last_of_block set ends the block: busy then stays high while the
// meter finishes the last addition, loads the divider, runs the bit-serial
// mean divider, loads the root unit, runs the two-bit-per-cycle square root
// and then forms the result in a final state, and rsp_valid pulses for one
// cycle just as busy falls, so a new block may start in that same cycle. The
// result cannot be held off; the receiver must take it in the strobe cycle.
// Limit writes on the csr_ channel are always ready and should be made
// between blocks.
module block_rms_level_meter_core #(
   parameter int MAX_BLOCK_SAMPLES = 8192
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [brlm_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                    req_last_of_block,
   output logic                                    rsp_valid,
   output logic [brlm_pkg::ROOT_BITS-1:0]          rsp_rms_level,
   output logic                                    rsp_above_limit,
   output logic                                    rsp_overflowed,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [brlm_pkg::LIMIT_BITS-1:0]         csr_level_limit
);

   brlm_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   brlm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .last  (req_last_of_block),
      .busy  (busy),
      .cmd   (cmd)
   );

   brlm_datapath #(
      .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sample_value    (req_sample_value),
      .csr_write       (csr_valid && csr_ready),
      .csr_level_limit (csr_level_limit),
      .rsp_valid       (rsp_valid),
      .rsp_rms_level   (rsp_rms_level),
      .rsp_above_limit (rsp_above_limit),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule

>>> rtl/core/brlm_ctrl.sv
// Controller state machine sequencing accumulation, division and square root.
`timescale 1ns / 1ps

module brlm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              last,
   output logic              busy,
   output brlm_pkg::cmd_type cmd
);

   brlm_pkg::state_type state_ff, state_in;
   logic [brlm_pkg::STEP_BITS-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brlm_pkg::ST_RUN;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         brlm_pkg::ST_RUN: begin
            busy       = 1'b0;
            cmd.accept = start;
            if (start && last) begin
               state_in = brlm_pkg::ST_SETTLE;
            end
         end
         // The last square is still being added to the sum in this cycle.
         brlm_pkg::ST_SETTLE: begin
            state_in = brlm_pkg::ST_DIV_LOAD;
         end
         brlm_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = brlm_pkg::ST_DIV;
         end
         brlm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == brlm_pkg::STEP_BITS'(brlm_pkg::SUM_BITS - 1)) begin
               step_in  = '0;
               state_in = brlm_pkg::ST_ROOT_LOAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         brlm_pkg::ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            step_in       = '0;
            state_in      = brlm_pkg::ST_ROOT;
         end
         brlm_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == brlm_pkg::STEP_BITS'(brlm_pkg::ROOT_BITS - 1)) begin
               step_in  = '0;
               state_in = brlm_pkg::ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         brlm_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = brlm_pkg::ST_RUN;
         end
         default: begin
            state_in = brlm_pkg::ST_RUN;
         end
      endcase
   end

   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && last) |=> busy)
      else $error("block end request did not make the meter busy");

   a_div_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brlm_pkg::ST_DIV) |->
         (step_ff < brlm_pkg::STEP_BITS'(brlm_pkg::SUM_BITS)))
      else $error("divider step count out of range");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !busy)
      else $error("meter did not return to accepting after a result");

endmodule

>>> rtl/core/brlm_datapath.sv
// Datapath: squaring, saturating accumulation, serial divider and square root.
`timescale 1ns / 1ps

module brlm_datapath #(
   parameter int MAX_BLOCK_SAMPLES = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  brlm_pkg::cmd_type                     cmd,
   input  logic signed [brlm_pkg::SAMPLE_BITS-1:0] sample_value,
   input  logic                                  csr_write,
   input  logic [brlm_pkg::LIMIT_BITS-1:0]        csr_level_limit,
   output logic                                  rsp_valid,
   output logic [brlm_pkg::ROOT_BITS-1:0]         rsp_rms_level,
   output logic                                  rsp_above_limit,
   output logic                                  rsp_overflowed
);

   localparam int CNT_BITS = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int MAG_BITS = brlm_pkg::SAMPLE_BITS + 1;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int SUM_W1   = brlm_pkg::SUM_BITS + 1;
   localparam int SQR_REM  = brlm_pkg::ROOT_BITS + 2;

   logic [brlm_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [CNT_BITS-1:0]             count_ff;
   logic                            dropped_ff;
   logic [brlm_pkg::SUM_BITS-1:0]   sum_ff;
   logic [SQ_BITS-1:0]              sq_ff;
   logic                            sq_vld_ff;

   logic [CNT_BITS-1:0]             div_rem_ff;
   logic [brlm_pkg::SUM_BITS-1:0]   div_quo_ff;
   logic [brlm_pkg::RAD_BITS-1:0]   rad_ff;
   logic [SQR_REM-1:0]              sqr_rem_ff;
   logic [brlm_pkg::ROOT_BITS-1:0]  root_ff;

   logic                            rsp_valid_ff;
   logic [brlm_pkg::ROOT_BITS-1:0]  rsp_rms_ff;
   logic                            rsp_above_ff;
   logic                            rsp_over_ff;

   logic [MAG_BITS-1:0]             sample_ext;
   logic [MAG_BITS-1:0]             mag;
   logic                            block_full;
   logic [SUM_W1-1:0]               sum_wide;
   logic [CNT_BITS:0]               div_trial;
   logic [CNT_BITS:0]               div_diff;
   logic                            div_ge;
   logic [SQR_REM-1:0]              sqr_trial_rem;
   logic [SQR_REM-1:0]              sqr_trial_sub;
   logic                            sqr_ge;
   logic [brlm_pkg::ROOT_BITS-1:0]  rms_value;

   always_comb begin
      sample_ext = {sample_value[brlm_pkg::SAMPLE_BITS-1], sample_value};
      mag        = sample_value[brlm_pkg::SAMPLE_BITS-1] ?
                   (~sample_ext + MAG_BITS'(1)) : sample_ext;
      block_full = (count_ff >= CNT_BITS'(MAX_BLOCK_SAMPLES));
      sum_wide   = {1'b0, sum_ff} + SUM_W1'(sq_ff);

      div_trial  = {div_rem_ff, div_quo_ff[brlm_pkg::SUM_BITS-1]};
      div_diff   = div_trial - {1'b0, count_ff};
      div_ge     = (div_trial >= {1'b0, count_ff});

      sqr_trial_rem = {sqr_rem_ff[SQR_REM-3:0], rad_ff[brlm_pkg::RAD_BITS-1 -: 2]};
      sqr_trial_sub = {root_ff, 2'b01};
      sqr_ge        = (sqr_trial_rem >= sqr_trial_sub);

      rms_value = (count_ff == '0) ? '0 : root_ff;
   end

   // Accumulation state.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= brlm_pkg::LIMIT_RESET;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sum_ff     <= '0;
         sq_vld_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            limit_ff <= csr_level_limit;
         end
         sq_vld_ff <= cmd.accept && !block_full;
         if (cmd.emit) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
            sum_ff     <= '0;
         end else begin
            if (cmd.accept) begin
               if (block_full) begin
                  dropped_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            // Sum saturates instead of wrapping.
            if (sq_vld_ff) begin
               sum_ff <= sum_wide[brlm_pkg::SUM_BITS] ? '1 :
                         sum_wide[brlm_pkg::SUM_BITS-1:0];
            end
         end
      end
   end

   // Square is registered before it meets the wide adder.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sq_ff <= SQ_BITS'(mag) * SQ_BITS'(mag);
      end
   end

   // Restoring divider, one quotient bit per cycle; the dividend shifts out of
   // the top of the quotient register as quotient bits shift in at the bottom.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_rem_ff <= '0;
         div_quo_ff <= sum_ff;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_diff[CNT_BITS-1:0] : div_trial[CNT_BITS-1:0];
         div_quo_ff <= {div_quo_ff[brlm_pkg::SUM_BITS-2:0], div_ge};
      end
   end

   // The mean of squares never exceeds the largest square, so the quotient
   // fits the radicand register and the root fits sixteen bits.
   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         rad_ff     <= div_quo_ff[brlm_pkg::RAD_BITS-1:0];
         sqr_rem_ff <= '0;
         root_ff    <= '0;
      end else if (cmd.root_step) begin
         rad_ff     <= {rad_ff[brlm_pkg::RAD_BITS-3:0], 2'b00};
         sqr_rem_ff <= sqr_ge ? (sqr_trial_rem - sqr_trial_sub) : sqr_trial_rem;
         root_ff    <= {root_ff[brlm_pkg::ROOT_BITS-2:0], sqr_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_rms_ff   <= rms_value;
         rsp_above_ff <= (rms_value > limit_ff);
         rsp_over_ff  <= dropped_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_level   = rsp_rms_ff;
   assign rsp_above_limit = rsp_above_ff;
   assign rsp_overflowed  = rsp_over_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_BLOCK_SAMPLES))
      else $error("sample count beyond block capacity");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_block_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> ((count_ff == '0) && !dropped_ff && (sum_ff == '0)))
      else $error("block state not cleared after a result");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the block RMS level meter core.
`timescale 1ns / 1ps

module tb;

   localparam int     MAX_BLOCK_SAMPLES = 8192;
   localparam int     RESULT_LATENCY    = 70;
   localparam int     WATCHDOG_LIMIT    = 2000;
   localparam longint SUM_CEILING       = (longint'(1) << brlm_pkg::SUM_BITS) - 1;

   typedef struct packed {
      logic [brlm_pkg::ROOT_BITS-1:0] rms_level;
      logic                           above_limit;
      logic                           overflowed;
   } level_result_type;

   logic                                    clock;
   logic                                    reset;
   logic                                    start;
   logic                                    busy;
   logic signed [brlm_pkg::SAMPLE_BITS-1:0] req_sample_value;
   logic                                    req_last_of_block;
   logic                                    rsp_valid;
   logic [brlm_pkg::ROOT_BITS-1:0]          rsp_rms_level;
   logic                                    rsp_above_limit;
   logic                                    rsp_overflowed;
   logic                                    csr_valid;
   logic                                    csr_ready;
   logic [brlm_pkg::LIMIT_BITS-1:0]         csr_level_limit;

   // Predicted meter state, kept in step with every accepted request.
   logic [brlm_pkg::LIMIT_BITS-1:0] meter_limit;
   longint                          block_sum;
   int                              block_count;
   logic                            block_dropped;
   level_result_type                pending_levels[$];

   int sender_idle_pct;
   int mismatch_count;

   block_rms_level_meter_core #(
      .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_value (req_sample_value),
      .req_last_of_block(req_last_of_block),
      .rsp_valid        (rsp_valid),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_above_limit  (rsp_above_limit),
      .rsp_overflowed   (rsp_overflowed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_level_limit  (csr_level_limit)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint floor_root(input longint radicand);
      longint root;
      longint trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root;
   endfunction

   function automatic void record_sample(input logic signed [15:0] value, input logic last);
      longint           magnitude;
      longint           square;
      longint           rms;
      level_result_type res;
      magnitude = (value < 0) ? -longint'(value) : longint'(value);
      if (block_count >= MAX_BLOCK_SAMPLES) begin
         block_dropped = 1'b1;
      end else begin
         square      = magnitude * magnitude;
         block_sum   = (square > SUM_CEILING - block_sum) ? SUM_CEILING : block_sum + square;
         block_count = block_count + 1;
      end
      if (last) begin
         rms             = (block_count != 0) ? floor_root(block_sum / block_count) : 0;
         res.rms_level   = rms[15:0];
         res.above_limit = rms > longint'(meter_limit);
         res.overflowed  = block_dropped;
         pending_levels.push_back(res);
         block_sum     = 0;
         block_count   = 0;
         block_dropped = 1'b0;
      end
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Enters and returns at a rising edge; the request is taken at the edge it returns on.
   task automatic send_sample(input logic signed [15:0] value, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_sample_value  <= value;
      req_last_of_block <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      record_sample(value, last);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic write_level_limit(input logic [15:0] value);
      drain_results();
      csr_valid       <= 1'b1;
      csr_level_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      meter_limit = value;
   endtask

   task automatic test_directed_levels();
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);
      // A level equal to the limit is not above it; one step higher is.
      send_sample(16'sd22938, 1'b1);
      send_sample(16'sd22939, 1'b1);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b1);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd200, 1'b0);
      send_sample(16'sd300, 1'b1);
   endtask

   task automatic test_level_limit_settings();
      write_level_limit(16'd0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd1, 1'b1);
      write_level_limit(16'd32768);
      send_sample(16'h8000, 1'b1);
      write_level_limit(16'd32767);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b1);
      write_level_limit(16'hFFFF);
      send_sample(16'h8000, 1'b1);
      write_level_limit(brlm_pkg::LIMIT_RESET);
   endtask

   task automatic test_full_block_overflow();
      // A full block of the most negative sample saturates the sum; the two
      // extra samples, the marked one included, are dropped.
      for (int i = 1; i <= MAX_BLOCK_SAMPLES + 2; i++)
         send_sample(16'h8000, i == MAX_BLOCK_SAMPLES + 2);
      for (int i = 1; i <= MAX_BLOCK_SAMPLES; i++)
         send_sample(pick_sample(), i == MAX_BLOCK_SAMPLES);
      for (int i = 1; i <= MAX_BLOCK_SAMPLES + 1; i++)
         send_sample(pick_sample(), i == MAX_BLOCK_SAMPLES + 1);
   endtask

   task automatic test_random_blocks(input int idle_pct, input int item_budget);
      int sent;
      int len;
      sender_idle_pct = idle_pct;
      write_level_limit(16'($urandom_range(0, 32768)));
      sent = 0;
      while (sent < item_budget) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
         for (int i = 1; i <= len; i++) send_sample(pick_sample(), i == len);
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      level_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            $error("unexpected result: rms_level %0d", rsp_rms_level);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_rms_level !== want.rms_level) begin
               $error("rms_level: expected %0d, got %0d", want.rms_level, rsp_rms_level);
               mismatch_count++;
            end
            if (rsp_above_limit !== want.above_limit) begin
               $error("above_limit: expected %0d, got %0d", want.above_limit,
                      rsp_above_limit);
               mismatch_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed: expected %0d, got %0d", want.overflowed, rsp_overflowed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("block_rms_level_meter_core: mismatch");
      $finish;
   end

   initial begin
      mismatch_count    = 0;
      sender_idle_pct   = 30;
      meter_limit       = brlm_pkg::LIMIT_RESET;
      block_sum         = 0;
      block_count       = 0;
      block_dropped     = 1'b0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_sample_value  <= '0;
      req_last_of_block <= 1'b0;
      csr_valid         <= 1'b0;
      csr_level_limit   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_levels();
      test_level_limit_settings();
      test_full_block_overflow();
      test_random_blocks(30, 340);
      test_random_blocks(56, 340);
      test_random_blocks(0, 340);

      drain_results();
      if (mismatch_count == 0)
         $display("block_rms_level_meter_core: match");
      else
         $display("block_rms_level_meter_core: mismatch");
      $finish;
   end

endmodule
